// ===== hw/rtl/pltk_pkg.sv =====
// Shared types and constants for the per-list top-K keeper.
// Holds the request, result, entry and queued-command structs and the ordering function.
// No dependencies.
`default_nettype none

package pltk_pkg;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // A query never reports more than this many entries.
    localparam int MaxOut = 8;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  list_id;
        logic [23:0] cand_ref;
        logic [7:0]  cand_len;
        logic [30:0] cand_freq;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [23:0] out_ref;
        logic [7:0]  out_len;
        logic [30:0] out_freq;
        logic [2:0]  rank;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [23:0] wref;
        logic [7:0]  len;
        logic [30:0] freq;
    } entry_t;

    typedef struct packed {
        logic        is_query;
        logic        in_range;
        logic [9:0]  list_id;
        entry_t      ent;
    } cmd_t;

    // True if a sorts strictly ahead of b: higher frequency, then shorter length.
    function automatic logic ranks_before(entry_t a, entry_t b);
        logic res;
        if (a.freq != b.freq)
        begin
            res = (a.freq > b.freq);
        end
        else
        begin
            res = (a.len < b.len);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pltk_front.sv =====
// Front end of the top-K keeper: accepts beats, classifies them and queues commands.
// Depends on pltk_pkg.
`default_nettype none

module pltk_front #(
    parameter int NUM_LISTS = 1024
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire pltk_pkg::item_t item,
    input  wire logic           clearing,
    output logic                busy,
    output logic                head_valid,
    output pltk_pkg::cmd_t      head,
    input  wire logic           pop
);

    pltk_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           accept;
    logic           in_range;
    logic           push;
    pltk_pkg::cmd_t cmd_in;

    assign busy       = (count_reg == 2'd2) || clearing;
    assign accept     = start && !busy;
    assign in_range   = (int'(item.list_id) < NUM_LISTS);
    // An insert to a list that does not exist has no effect, so it is never queued.
    assign push       = accept && ((item.req_type == pltk_pkg::REQ_QUERY) || in_range);
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.is_query = (item.req_type == pltk_pkg::REQ_QUERY);
        cmd_in.in_range = in_range;
        cmd_in.list_id  = item.list_id;
        cmd_in.ent.wref = item.cand_ref;
        cmd_in.ent.len  = item.cand_len;
        cmd_in.ent.freq = item.cand_freq;
        count_next      = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pltk_back.sv =====
// Back end of the top-K keeper: owns the fill-count and entry memories, runs
// sorted inserts as a descending row scan and streams query results.
// Depends on pltk_pkg.
`default_nettype none

module pltk_back #(
    parameter int TOP_K     = 8,
    parameter int NUM_LISTS = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire pltk_pkg::cmd_t  head,
    output logic                 pop,
    output logic                 clearing,
    output logic                 strobe,
    output pltk_pkg::result_t    result
);

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int SLOT_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int CNT_W  = $clog2(TOP_K + 1);
    localparam int AW     = LIST_W + SLOT_W;
    localparam int ENT_DEPTH = NUM_LISTS * (1 << SLOT_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_QOUT,
        S_SCAN,
        S_PUT
    } state_t;

    logic [CNT_W-1:0]    fill_mem [NUM_LISTS];
    pltk_pkg::entry_t    ent_mem  [ENT_DEPTH];

    state_t              state_reg,    state_next;
    pltk_pkg::cmd_t      cmd_reg,      cmd_next;
    logic [SLOT_W-1:0]   i_reg,        i_next;
    logic [3:0]          qn_reg,       qn_next;
    logic                full_reg,     full_next;
    logic                clearing_reg, clearing_next;
    logic [LIST_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                strobe_reg,   strobe_next;
    pltk_pkg::result_t   result_reg,   result_next;

    logic [CNT_W-1:0]    fill_rd_reg;
    pltk_pkg::entry_t    ent_rd_reg;

    logic                fill_we;
    logic [LIST_W-1:0]   fill_wa;
    logic [CNT_W-1:0]    fill_wd;
    logic [LIST_W-1:0]   fill_ra;
    logic                ent_we;
    logic [AW-1:0]       ent_wa;
    pltk_pkg::entry_t    ent_wd;
    logic [AW-1:0]       ent_ra;

    logic [LIST_W-1:0]   lst;
    logic [LIST_W-1:0]   head_lst;
    logic                last_hit;

    assign lst      = LIST_W'({6'd0, cmd_reg.list_id});
    assign head_lst = LIST_W'({6'd0, head.list_id});
    assign last_hit = ((4'(i_reg) + 4'd1) == qn_reg);
    assign clearing = clearing_reg;
    assign strobe   = strobe_reg;
    assign result   = result_reg;

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_wa] <= fill_wd;
        end
        fill_rd_reg <= fill_mem[fill_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        ent_rd_reg <= ent_mem[ent_ra];
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        i_next        = i_reg;
        qn_next       = qn_reg;
        full_next     = full_reg;
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        pop           = 1'b0;
        fill_we       = 1'b0;
        fill_wa       = lst;
        fill_wd       = '0;
        fill_ra       = head_lst;
        ent_we        = 1'b0;
        ent_wa        = {lst, i_reg};
        ent_wd        = cmd_reg.ent;
        ent_ra        = {lst, i_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (clearing_reg)
                begin
                    fill_we       = 1'b1;
                    fill_wa       = clr_addr_reg;
                    clr_addr_next = clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LIST_W'(NUM_LISTS - 1))
                    begin
                        clearing_next = 1'b0;
                    end
                end
                else if (head_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    if (head.is_query && !head.in_range)
                    begin
                        strobe_next      = 1'b1;
                        result_next      = '0;
                        result_next.last = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CNT;
                    end
                end
            end

            S_CNT:
            begin
                if (cmd_reg.is_query)
                begin
                    if (fill_rd_reg == '0)
                    begin
                        strobe_next      = 1'b1;
                        result_next      = '0;
                        result_next.last = 1'b1;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        qn_next    = (int'(fill_rd_reg) > pltk_pkg::MaxOut)
                                     ? 4'(pltk_pkg::MaxOut) : 4'(fill_rd_reg);
                        i_next     = '0;
                        ent_ra     = {lst, SLOT_W'(0)};
                        state_next = S_QOUT;
                    end
                end
                else if (fill_rd_reg == '0)
                begin
                    ent_we     = 1'b1;
                    ent_wa     = {lst, SLOT_W'(0)};
                    fill_we    = 1'b1;
                    fill_wd    = CNT_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    // Scan the row from its tail toward the head, shifting down as we go.
                    i_next     = SLOT_W'(fill_rd_reg - 1'b1);
                    ent_ra     = {lst, SLOT_W'(fill_rd_reg - 1'b1)};
                    full_next  = (fill_rd_reg == CNT_W'(TOP_K));
                    fill_we    = (fill_rd_reg != CNT_W'(TOP_K));
                    fill_wd    = fill_rd_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end

            S_QOUT:
            begin
                strobe_next          = 1'b1;
                result_next.found    = 1'b1;
                result_next.out_ref  = ent_rd_reg.wref;
                result_next.out_len  = ent_rd_reg.len;
                result_next.out_freq = ent_rd_reg.freq;
                result_next.rank     = 3'(i_reg);
                result_next.last     = last_hit;
                i_next               = i_reg + 1'b1;
                ent_ra               = {lst, i_reg + 1'b1};
                if (last_hit)
                begin
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                ent_ra = {lst, i_reg - 1'b1};
                if (full_reg)
                begin
                    // Only a candidate of higher frequency evicts the weakest entry.
                    full_next = 1'b0;
                    if (cmd_reg.ent.freq > ent_rd_reg.freq)
                    begin
                        if (i_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            i_next = i_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (pltk_pkg::ranks_before(cmd_reg.ent, ent_rd_reg))
                begin
                    ent_we = 1'b1;
                    ent_wa = {lst, i_reg + 1'b1};
                    ent_wd = ent_rd_reg;
                    if (i_reg == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        i_next = i_reg - 1'b1;
                    end
                end
                else
                begin
                    ent_we     = 1'b1;
                    ent_wa     = {lst, i_reg + 1'b1};
                    state_next = S_IDLE;
                end
            end

            S_PUT:
            begin
                ent_we     = 1'b1;
                ent_wa     = {lst, SLOT_W'(0)};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            qn_reg       <= '0;
            full_reg     <= 1'b0;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            qn_reg       <= qn_next;
            full_reg     <= full_next;
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !strobe_reg)
        else $error("result beat during fill-count clearing");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !result_reg.found) |-> result_reg.last)
        else $error("empty-list result beat not marked last");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> (fill_wd <= CNT_W'(TOP_K)))
        else $error("fill count written above list capacity");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/per_list_top_k_keeper_core.sv =====
// Top level of the per-list top-K keeper.
// Depends on pltk_pkg, pltk_front and pltk_back.
//
// Usage:
//   A request beat is taken at a rising edge with start high and busy low. req_type
//   selects an insert (no result) or a query of list list_id. Results appear one per
//   cycle with strobe high for exactly one cycle each; the receiver cannot stall.
//   A query returns the list's entries best first (up to eight, last set on the final
//   beat), or a single beat with found low for an empty or nonexistent list.
//   A query pops from the queue, reads the fill count, then streams its results one
//   beat per cycle. An insert reads the fill count, then scans the row's entries
//   from the tail toward the head, moving each weaker one back a slot.
//   A two-deep command queue separates the front from the back; busy rises when it
//   is full. After reset, busy stays high while every list's fill count is cleared
//   to zero; all lists then read as empty.
`default_nettype none

module per_list_top_k_keeper_core #(
    parameter int TOP_K     = 8,
    parameter int NUM_LISTS = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire pltk_pkg::item_t   item,
    output logic                   busy,
    output logic                   strobe,
    output pltk_pkg::result_t      result
);

    logic           head_valid;
    pltk_pkg::cmd_t head;
    logic           pop;
    logic           clearing;

    pltk_front #(
        .NUM_LISTS (NUM_LISTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .clearing   (clearing),
        .busy       (busy),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    pltk_back #(
        .TOP_K     (TOP_K),
        .NUM_LISTS (NUM_LISTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clearing   (clearing),
        .strobe     (strobe),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== bench/tb_per_list_top_k_keeper_core.sv =====
// Self-checking testbench for per_list_top_k_keeper_core: directed rows, then random
// inserts and queries against a behavioral list keeper, with random gaps on the sender.
// Depends on pltk_pkg and the keeper RTL.
`default_nettype none

module tb_per_list_top_k_keeper_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pltk_pkg::*;

    localparam int TOP_K        = 8;
    localparam int NUM_LISTS    = 1024;
    localparam int RANDOM_BEATS = 347;
    localparam int HOT_LISTS    = 16;
    localparam int MAX_REPORTS  = 10;

    localparam result_t EMPTY_REPLY = '{1'b0, 24'd0, 8'd0, 31'd0, 3'd0, 1'b1};
    localparam result_t TOP_REPLY   = '{1'b1, 24'hFFFFFF, 8'hFF, 31'h7FFFFFFF, 3'd0, 1'b1};
    localparam result_t ZERO_REPLY  = '{1'b1, 24'd0, 8'd0, 31'd0, 3'd0, 1'b1};

    typedef struct {
        item_t   req;
        bit      typed;
        result_t want;
    } row_t;

    logic    clk    = 1'b0;
    logic    rst_n  = 1'b0;
    logic    start  = 1'b0;
    item_t   item   = '0;
    logic    busy;
    logic    strobe;
    result_t result;

    // Behavioral copy of the lists, kept in sorted order.
    int unsigned fill_cnt [NUM_LISTS];
    entry_t      kept     [NUM_LISTS][TOP_K];

    result_t     pending_beats[$];
    result_t     model_reply[$];
    row_t        directed_rows[$];
    logic [9:0]  hot_ids[HOT_LISTS];

    int n_errors    = 0;
    int n_checked   = 0;
    int n_inserts   = 0;
    int n_queries   = 0;
    int n_evictions = 0;
    int n_dropped   = 0;
    bit no_idle     = 1'b0;

    per_list_top_k_keeper_core #(
        .TOP_K     (TOP_K),
        .NUM_LISTS (NUM_LISTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d result beats still pending.", pending_beats.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Put a candidate at its sorted position among the first count entries of a list.
    function automatic void slot_in(int id, int unsigned count, entry_t c);
        int unsigned pos;
        pos = 0;
        while (pos < count && !((c.freq > kept[id][pos].freq) ||
                                (c.freq == kept[id][pos].freq && c.len < kept[id][pos].len)))
        begin
            pos++;
        end
        for (int unsigned i = count; i > pos; i--)
        begin
            kept[id][i] = kept[id][i - 1];
        end
        kept[id][pos] = c;
    endfunction

    // Update the lists for one accepted beat and leave its result beats in model_reply.
    function automatic void keeper_apply(item_t it);
        entry_t      c;
        int unsigned cnt;
        result_t     r;
        model_reply.delete();
        cnt = fill_cnt[it.list_id];
        if (it.req_type == REQ_INSERT)
        begin
            n_inserts++;
            c.wref = it.cand_ref;
            c.len  = it.cand_len;
            c.freq = it.cand_freq;
            if (cnt < TOP_K)
            begin
                slot_in(it.list_id, cnt, c);
                fill_cnt[it.list_id] = cnt + 1;
            end
            else if (c.freq > kept[it.list_id][TOP_K - 1].freq)
            begin
                slot_in(it.list_id, TOP_K - 1, c);
                n_evictions++;
            end
            else
            begin
                n_dropped++;
            end
        end
        else
        begin
            n_queries++;
            if (cnt == 0)
            begin
                model_reply = {model_reply, EMPTY_REPLY};
            end
            else
            begin
                for (int unsigned k = 0; k < cnt && k < MaxOut; k++)
                begin
                    r.found    = 1'b1;
                    r.out_ref  = kept[it.list_id][k].wref;
                    r.out_len  = kept[it.list_id][k].len;
                    r.out_freq = kept[it.list_id][k].freq;
                    r.rank     = 3'(k);
                    r.last     = (k + 1 == cnt || k + 1 == MaxOut);
                    model_reply = {model_reply, r};
                end
            end
        end
    endfunction

    function automatic void add_row(logic rq, int id, int wref, int len, int freq,
                                    bit typed = 1'b0, result_t want = '0);
        row_t rw;
        rw.req.req_type  = rq;
        rw.req.list_id   = 10'(id);
        rw.req.cand_ref  = 24'(wref);
        rw.req.cand_len  = 8'(len);
        rw.req.cand_freq = 31'(freq);
        rw.typed         = typed;
        rw.want          = want;
        directed_rows    = {directed_rows, rw};
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.req_type = ($urandom_range(0, 99) < 30) ? REQ_QUERY : REQ_INSERT;
        if ($urandom_range(0, 99) < 30)
        begin
            it.list_id = 10'($urandom_range(0, NUM_LISTS - 1));
        end
        else
        begin
            it.list_id = hot_ids[$urandom_range(0, HOT_LISTS - 1)];
        end
        it.cand_ref = 24'($urandom());
        // Small lengths and frequencies make ties and equal-to-weakest cases common.
        it.cand_len = ($urandom_range(0, 99) < 40) ? 8'($urandom_range(0, 3)) : 8'($urandom());
        case ($urandom_range(0, 9))
            0:       it.cand_freq = 31'h7FFFFFFF;
            1:       it.cand_freq = 31'd0;
            2, 3, 4,
            5:       it.cand_freq = 31'($urandom_range(0, 15));
            default: it.cand_freq = 31'($urandom());
        endcase
        return it;
    endfunction

    // Offer one request beat and wait until the block takes it. Called at a rising edge.
    task automatic send_beat(item_t it, int gap, bit typed, result_t want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        keeper_apply(it);
        if (typed)
        begin
            pending_beats = {pending_beats, want};
        end
        else
        begin
            foreach (model_reply[i])
            begin
                pending_beats = {pending_beats, model_reply[i]};
            end
        end
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && strobe)
        begin
            if (pending_beats.size() == 0)
            begin
                flag_error($sformatf("result beat with nothing pending: %p", result));
            end
            else
            begin
                want = pending_beats.pop_front();
                n_checked++;
                if (result.found !== want.found || result.out_ref !== want.out_ref ||
                    result.out_len !== want.out_len || result.out_freq !== want.out_freq ||
                    result.rank !== want.rank || result.last !== want.last)
                begin
                    flag_error($sformatf("result mismatch: expected %p, got %p", want, result));
                end
            end
        end
    end

    initial
    begin
        foreach (fill_cnt[i])
        begin
            fill_cnt[i] = 0;
        end

        // Empty lists right after reset, then the field extremes.
        add_row(REQ_QUERY,  0,    0,        0,    0,            1'b1, EMPTY_REPLY);
        add_row(REQ_QUERY,  1023, 0,        0,    0,            1'b1, EMPTY_REPLY);
        add_row(REQ_INSERT, 1023, 24'hFFFFFF, 255, 32'h7FFFFFFF);
        add_row(REQ_QUERY,  1023, 0,        0,    0,            1'b1, TOP_REPLY);
        add_row(REQ_INSERT, 0,    0,        0,    0);
        add_row(REQ_QUERY,  0,    0,        0,    0,            1'b1, ZERO_REPLY);
        // Fill one list with ties on frequency and on both keys.
        add_row(REQ_INSERT, 7, 1, 5, 100);
        add_row(REQ_INSERT, 7, 2, 5, 100);
        add_row(REQ_INSERT, 7, 3, 3, 100);
        add_row(REQ_INSERT, 7, 4, 7, 200);
        add_row(REQ_INSERT, 7, 5, 2, 50);
        add_row(REQ_INSERT, 7, 6, 1, 50);
        add_row(REQ_INSERT, 7, 7, 4, 10);
        add_row(REQ_INSERT, 7, 8, 9, 10);
        // Full list: equal to the weakest is dropped, one above it evicts.
        add_row(REQ_INSERT, 7, 9,  0,   10);
        add_row(REQ_INSERT, 7, 10, 200, 11);
        add_row(REQ_QUERY,  7, 0,  0,   0);
        add_row(REQ_INSERT, 7, 11, 0,   0);
        add_row(REQ_INSERT, 7, 12, 255, 32'h7FFFFFFF);
        add_row(REQ_QUERY,  7, 0,  0,   0);
        add_row(REQ_QUERY,  512, 0, 0, 0, 1'b1, EMPTY_REPLY);
        add_row(REQ_INSERT, 512, 24'hAAAAAA, 8'h55, 32'h2AAAAAAA);
        add_row(REQ_QUERY,  512, 0, 0, 0);

        hot_ids[0] = 10'd7;
        for (int i = 1; i < HOT_LISTS; i++)
        begin
            hot_ids[i] = 10'($urandom_range(0, NUM_LISTS - 1));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i].req, pick_gap(), directed_rows[i].typed,
                      directed_rows[i].want);
        end
        drain_pending();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 40 == 0)
            begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            // Now and then let the block run dry before the next beat.
            if (n % 60 == 59)
            begin
                drain_pending();
            end
            send_beat(random_item(), pick_gap(), 1'b0, '0);
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TOP_K + 6) @(posedge clk);

        $display("Sent %0d inserts (%0d evicted the weakest, %0d dropped) and %0d queries.",
                 n_inserts, n_evictions, n_dropped, n_queries);
        $display("Checked %0d result beats, %0d errors.", n_checked, n_errors);
        if (n_errors == 0 && pending_beats.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/pltk_pkg.sv
hw/rtl/pltk_front.sv
hw/rtl/pltk_back.sv
hw/rtl/per_list_top_k_keeper_core.sv
bench/tb_per_list_top_k_keeper_core.sv
